FILE: rtl/core/ttip_pkg.sv
// ----------------------------------------------------------------------------
// ttip_pkg
// Shared types and constants of the text-to-integer parser.
// ----------------------------------------------------------------------------
package ttip_pkg;

  localparam int unsigned MAX_LEN = 4096;
  localparam int unsigned CNT_W   = 13;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned BASE_W  = 6;
  localparam int unsigned DIGIT_W = 6;

  // configuration register indexes
  localparam logic REG_NUMBER_BASE = 1'b0;
  localparam logic REG_SIGNED_MODE = 1'b1;

  // classified byte, handed from front to back
  typedef struct packed {
    logic               is_digit;
    logic [DIGIT_W-1:0] digit;
    logic               is_space;
    logic               is_plus;
    logic               is_minus;
    logic               is_zero;
    logic               is_x;
    logic               start;
    logic               last;
  } cls_t;

endpackage

FILE: rtl/core/ttip_front.sv
// ----------------------------------------------------------------------------
// ttip_front
// Accepts bytes, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module ttip_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    char_byte_i,
  input  logic          string_start_i,
  input  logic          string_last_i,
  output logic          q_valid_o,
  output ttip_pkg::cls_t q_item_o,
  input  logic          q_pop_i
);

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7a;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5a;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] TEN      = 8'd10;

  ttip_pkg::cls_t cls;
  ttip_pkg::cls_t entry_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           push;
  logic           pop;
  logic [7:0]     dval;

  always_comb begin
    dval         = 8'd0;
    cls.is_digit = 1'b1;
    if (char_byte_i >= CH_0 && char_byte_i <= CH_9) begin
      dval = char_byte_i - CH_0;
    end else if (char_byte_i >= CH_LA && char_byte_i <= CH_LZ) begin
      dval = char_byte_i - CH_LA + TEN;
    end else if (char_byte_i >= CH_UA && char_byte_i <= CH_UZ) begin
      dval = char_byte_i - CH_UA + TEN;
    end else begin
      cls.is_digit = 1'b0;
    end
    cls.digit    = dval[ttip_pkg::DIGIT_W-1:0];
    cls.is_space = (char_byte_i == CH_SP) || (char_byte_i == CH_TAB) ||
                   (char_byte_i == CH_LF) || (char_byte_i == CH_CR);
    cls.is_plus  = (char_byte_i == CH_PLUS);
    cls.is_minus = (char_byte_i == CH_MINUS);
    cls.is_zero  = (char_byte_i == CH_0);
    cls.is_x     = (char_byte_i == CH_LX) || (char_byte_i == CH_UX);
    cls.start    = string_start_i;
    cls.last     = string_last_i;
  end

  assign in_ready_o = (count_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && (count_q != 2'd0);
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cls;
    end
  end

endmodule

FILE: rtl/core/ttip_back.sv
// ----------------------------------------------------------------------------
// ttip_back
// Parse sequencer: sign and prefix handling, digit accumulation, result
// register.
// ----------------------------------------------------------------------------
module ttip_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [ttip_pkg::BASE_W-1:0]     cfg_wdata_i,
  input  logic                            q_valid_i,
  input  ttip_pkg::cls_t                  q_item_i,
  output logic                            q_pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ttip_pkg::VALUE_W-1:0]    parsed_value_o,
  output logic [ttip_pkg::CNT_W-1:0]      bytes_consumed_o
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_LEAD   = 3'd1;
  localparam logic [2:0] PH_PREFIX = 3'd2;
  localparam logic [2:0] PH_ZERO   = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;

  localparam int unsigned VW = ttip_pkg::VALUE_W;
  localparam int unsigned BW = ttip_pkg::BASE_W;
  localparam int unsigned CW = ttip_pkg::CNT_W;

  localparam logic [BW-1:0] BASE_8  = BW'(8);
  localparam logic [BW-1:0] BASE_10 = BW'(10);
  localparam logic [BW-1:0] BASE_16 = BW'(16);
  localparam logic [CW-1:0] CNT_MAX = CW'(ttip_pkg::MAX_LEN);

  logic [BW-1:0]    number_base_q;
  logic             signed_mode_q;

  logic [2:0]       phase_q, phase_d;
  logic [VW-1:0]    acc_q, acc_d;
  logic             minus_q, minus_d;
  logic [BW-1:0]    base_q, base_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  logic             out_valid_q, out_valid_d;
  logic [VW-1:0]    value_q;
  logic [CW-1:0]    bytes_q;

  logic             consumed;
  logic             done;
  logic [VW+BW-1:0] prod;

  ttip_pkg::cls_t   it;

  assign it      = q_item_i;
  assign q_pop_o = q_valid_i && (!out_valid_q || out_ready_i);

  // one byte per pass, every phase transition the byte can cause in one go
  always_comb begin
    phase_d  = it.start ? PH_LEAD : phase_q;
    acc_d    = it.start ? '0 : acc_q;
    minus_d  = it.start ? 1'b0 : minus_q;
    base_d   = it.start ? '0 : base_q;
    cnt_d    = it.start ? '0 : cnt_q;
    consumed = 1'b0;
    done     = 1'b0;
    prod     = '0;

    if (phase_d != PH_IDLE) begin
      if (phase_d == PH_LEAD) begin
        if (it.is_space) begin
          consumed = 1'b1;
        end else if (it.is_plus) begin
          consumed = 1'b1;
          phase_d  = PH_PREFIX;
        end else if (it.is_minus && signed_mode_q) begin
          consumed = 1'b1;
          minus_d  = 1'b1;
          phase_d  = PH_PREFIX;
        end else begin
          phase_d  = PH_PREFIX;
        end
      end

      if (!consumed && phase_d == PH_PREFIX) begin
        if (it.is_zero && (number_base_q == '0 || number_base_q == BASE_16)) begin
          base_d   = (number_base_q == '0) ? BASE_8 : BASE_16;
          acc_d    = '0;
          consumed = 1'b1;
          phase_d  = PH_ZERO;
        end else begin
          base_d   = (number_base_q == '0) ? BASE_10 : number_base_q;
          phase_d  = PH_DIGITS;
        end
      end else if (!consumed && phase_d == PH_ZERO) begin
        if (it.is_x) begin
          base_d   = BASE_16;
          consumed = 1'b1;
        end
        phase_d = PH_DIGITS;
      end

      if (!consumed && phase_d == PH_DIGITS) begin
        if (it.is_digit && (BW'(it.digit) < base_d)) begin
          prod     = {{BW{1'b0}}, acc_d} * {{VW{1'b0}}, base_d};
          acc_d    = prod[VW-1:0] + VW'(it.digit);
          consumed = 1'b1;
        end else begin
          done = 1'b1;
        end
      end

      if (consumed) begin
        if (cnt_d < CNT_MAX) begin
          cnt_d = cnt_d + CW'(1);
        end
        if (it.last) begin
          done = 1'b1;
        end
      end

      if (done) begin
        phase_d = PH_IDLE;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (q_pop_o && done) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_base_q <= '0;
      signed_mode_q <= 1'b1;
      phase_q       <= PH_IDLE;
      acc_q         <= '0;
      minus_q       <= 1'b0;
      base_q        <= '0;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ttip_pkg::REG_NUMBER_BASE: number_base_q <= cfg_wdata_i;
          ttip_pkg::REG_SIGNED_MODE: signed_mode_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (q_pop_o) begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        minus_q <= minus_d;
        base_q  <= base_d;
        cnt_q   <= cnt_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && done) begin
      value_q <= minus_d ? (VW'(0) - acc_d) : acc_d;
      bytes_q <= cnt_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign parsed_value_o   = value_q;
  assign bytes_consumed_o = bytes_q;

endmodule

FILE: rtl/core/text_to_integer_parser.sv
// ----------------------------------------------------------------------------
// text_to_integer_parser
// Streaming strtol/strtoul-style parser: bytes in, 64-bit integers out.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) takes one byte item per cycle while
// in_ready_o is high, with string_start_i marking the first byte of a string
// and string_last_i the final one. Output channel (out_valid_o/out_ready_i)
// gives one item per finished parse: the value and the number of bytes
// consumed. The front classifies each byte into a two-entry queue; the back
// pops one entry per cycle, unless a result is pending and out_ready_i is
// low, and runs the parse. Throughput is one byte per cycle under the same
// condition, set by the back's combinational multiply-accumulate of a 64-bit
// value by a 6-bit base. The ending byte enters the queue when accepted; the
// back then pops it, after any bytes waiting ahead of it, and loads the
// result register and raises out_valid_o.
// Configuration: cfg_we_i writes register cfg_idx_i (0 number_base,
// 1 signed_mode) at once.
// Reset empties the queue, returns the parser to idle, sets number_base to 0
// and signed_mode to 1. If the receiver stalls with a result pending, the
// back stops popping and the queue fills; in_ready_o falls once it holds two
// bytes, and nothing is dropped.
// ----------------------------------------------------------------------------
module text_to_integer_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [ttip_pkg::BASE_W-1:0]  cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   char_byte_i,
  input  logic                         string_start_i,
  input  logic                         string_last_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ttip_pkg::VALUE_W-1:0] parsed_value_o,
  output logic [ttip_pkg::CNT_W-1:0]   bytes_consumed_o
);

  logic           q_valid;
  logic           q_pop;
  ttip_pkg::cls_t q_item;

  ttip_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .char_byte_i    (char_byte_i),
    .string_start_i (string_start_i),
    .string_last_i  (string_last_i),
    .q_valid_o      (q_valid),
    .q_item_o       (q_item),
    .q_pop_i        (q_pop)
  );

  ttip_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .q_valid_i        (q_valid),
    .q_item_i         (q_item),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .parsed_value_o   (parsed_value_o),
    .bytes_consumed_o (bytes_consumed_o)
  );

endmodule
